[hw/rtl/smi_pkg.sv]
// Shared constants, types and helpers for the servo motion interpolator.
`timescale 1ns / 1ps

package smi_pkg;

    // Joint and pulse geometry
    localparam int ALL_JOINTS = 6;
    localparam int JOINTS     = 6;
    localparam int PULSE_LOW  = 102;
    localparam int PULSE_HIGH = 512;
    localparam int SPAN       = PULSE_HIGH - PULSE_LOW;
    localparam int MAX_DEG    = 180;
    localparam int HOME_DEG   = 90;
    localparam int HOME_PULSE = PULSE_LOW + SPAN * HOME_DEG / MAX_DEG;

    // Field widths
    localparam int CMD_W   = 3;
    localparam int JOINT_W = 3;
    localparam int DEG_W   = 10;
    localparam int PULSE_W = 10;
    localparam int STEP_W  = 8;
    localparam int ANGLE_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Serial multiply-divide operand widths
    localparam int MD_A_W = PULSE_W;
    localparam int MD_B_W = STEP_W;
    localparam int MD_C_W = PULSE_W;
    localparam int MD_P_W = MD_A_W + MD_B_W;
    localparam int MD_CNT_W = $clog2(MD_P_W);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DOWN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_HOME = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_STEPS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_STEPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JOG_DEG    = 2'd2;

    typedef logic [PULSE_W-1:0] pulse_t;

    // Request to the serial unit: q = (a * b) / c
    typedef struct packed {
        logic              go;
        logic [MD_A_W-1:0] a;
        logic [MD_B_W-1:0] b;
        logic [MD_C_W-1:0] c;
    } smi_md_req_t;

    typedef struct packed {
        logic              done;
        logic [MD_P_W-1:0] q;
    } smi_md_rsp_t;

    // Clamp a signed angle to 0..MAX_DEG
    function automatic logic [ANGLE_W-1:0] clamp_deg(input logic signed [DEG_W-1:0] d);
        logic [ANGLE_W-1:0] r;
        if (d[DEG_W-1])
            r = '0;
        else if (d > DEG_W'(MAX_DEG))
            r = ANGLE_W'(MAX_DEG);
        else
            r = d[ANGLE_W-1:0];
        return r;
    endfunction

endpackage

[hw/rtl/smi_cmd_if.sv]
// Command channel: valid/ready with command, joint and angle payload.
`timescale 1ns / 1ps

interface smi_cmd_if;
    import smi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [JOINT_W-1:0]       joint;
    logic signed [DEG_W-1:0]  degrees;

    modport source (output valid, cmd, joint, degrees, input ready);
    modport sink   (input valid, cmd, joint, degrees, output ready);
endinterface

[hw/rtl/smi_frame_if.sv]
// Frame channel: valid/ready with six joint pulses and the final flag.
`timescale 1ns / 1ps

interface smi_frame_if;
    import smi_pkg::*;

    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] pulse_shoulder;
    logic [PULSE_W-1:0] pulse_elbow;
    logic [PULSE_W-1:0] pulse_wrist_pitch;
    logic [PULSE_W-1:0] pulse_wrist_roll;
    logic [PULSE_W-1:0] pulse_grabber;
    logic [PULSE_W-1:0] pulse_base;
    logic               final_frame;

    modport source (output valid, pulse_shoulder, pulse_elbow, pulse_wrist_pitch,
                    pulse_wrist_roll, pulse_grabber, pulse_base, final_frame,
                    input ready);
    modport sink   (input valid, pulse_shoulder, pulse_elbow, pulse_wrist_pitch,
                    pulse_wrist_roll, pulse_grabber, pulse_base, final_frame,
                    output ready);
endinterface

[hw/rtl/smi_muldiv.sv]
// Bit-serial unit computing (a * b) / c: shift-add multiply, then restoring divide.
`timescale 1ns / 1ps

module smi_muldiv (
    input  logic                 clk,
    input  logic                 rst_n,
    input  smi_pkg::smi_md_req_t req,
    output smi_pkg::smi_md_rsp_t rsp
);
    import smi_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]          phase_reg, phase_next;
    logic [MD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [MD_P_W-1:0]   acc_reg, acc_next;
    logic [MD_P_W-1:0]   mcand_reg, mcand_next;
    logic [MD_B_W-1:0]   mplier_reg, mplier_next;
    logic [MD_C_W-1:0]   div_reg, div_next;
    logic [MD_C_W-1:0]   rem_reg, rem_next;

    logic [MD_C_W:0]     trial;
    logic                ge;

    // One divide step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, acc_reg[MD_P_W-1]};
    assign ge    = (trial >= {1'b0, div_reg});

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (req.go)
                begin
                    acc_next    = '0;
                    mcand_next  = MD_P_W'(req.a);
                    mplier_next = req.b;
                    div_next    = req.c;
                    cnt_next    = MD_CNT_W'(MD_B_W - 1);
                    phase_next  = PH_MUL;
                end
            end
            PH_MUL:
            begin
                // one multiplier bit per cycle
                if (mplier_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next  = {mcand_reg[MD_P_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[MD_B_W-1:1]};
                if (cnt_reg == '0)
                begin
                    cnt_next   = MD_CNT_W'(MD_P_W - 1);
                    rem_next   = '0;
                    phase_next = PH_DIV;
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            PH_DIV:
            begin
                // one quotient bit per cycle, shifted into the dividend register
                rem_next = ge ? MD_C_W'(trial - {1'b0, div_reg}) : trial[MD_C_W-1:0];
                acc_next = {acc_reg[MD_P_W-2:0], ge};
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            default:
                phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = acc_reg;

endmodule

[hw/rtl/servo_motion_interpolator.sv]
// Servo motion interpolator top level: command sequencer, joint state and frame output.
// Usage:
//   command channel (sink): cmd, joint, degrees. Set, jog up, jog down and home
//   are taken only while no move runs; otherwise they are dropped. A frame tick
//   during a move produces one beat on the frame channel; a tick while idle
//   produces nothing.
//   frame channel (source): six joint pulse widths in ticks and final_frame,
//   set on the frame that completes the move.
//   Config port: cfg_we/cfg_index/cfg_data write set_steps (0), home_steps (1)
//   and jog_degrees (2). Write only while idle.
// Sequencing: one command is processed at a time by a shared bit-serial
//   multiply-divide unit; each operation loads its operands, then takes one
//   multiplier bit per step and then one quotient bit per step. Home uses no
//   operation, set one, jog two, and a frame tick six before its beat is offered.
// Reset: all joints load the 90 degree pulse (307), no move runs, the
//   registers return to 20, 75 and 5. No home move is made.
// Stall: a finished beat waits in the output register while the next command
//   is taken; a following tick completes its work and then holds until the
//   frame channel takes the waiting beat.
`timescale 1ns / 1ps

module servo_motion_interpolator (
    input  logic                             clk,
    input  logic                             rst_n,
    smi_cmd_if.sink                          command,
    smi_frame_if.source                      frame,
    input  logic                             cfg_we,
    input  logic [smi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [smi_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import smi_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_P2A    = 3'd1;
    localparam logic [2:0] S_A2P    = 3'd2;
    localparam logic [2:0] S_LAUNCH = 3'd3;
    localparam logic [2:0] S_INTERP = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [STEP_W-1:0]   set_steps_reg, set_steps_next;
    logic [STEP_W-1:0]   home_steps_reg, home_steps_next;
    logic [ANGLE_W-1:0]  jog_deg_reg, jog_deg_next;
    pulse_t              present_reg [ALL_JOINTS];
    pulse_t              present_next [ALL_JOINTS];
    pulse_t              start_reg [ALL_JOINTS];
    pulse_t              start_next [ALL_JOINTS];
    pulse_t              goal_reg [ALL_JOINTS];
    pulse_t              goal_next [ALL_JOINTS];
    pulse_t              res_reg [ALL_JOINTS];
    pulse_t              res_next [ALL_JOINTS];
    pulse_t              pulse_reg [ALL_JOINTS];
    pulse_t              pulse_next [ALL_JOINTS];
    logic                final_reg, final_next;
    logic                out_valid_reg, out_valid_next;
    logic [STEP_W-1:0]   idx_reg, idx_next;
    logic [STEP_W-1:0]   total_reg, total_next;
    logic                moving_reg, moving_next;
    logic                last_reg, last_next;
    logic [JOINT_W-1:0]  jidx_reg, jidx_next;
    logic [JOINT_W-1:0]  sel_reg, sel_next;
    logic                jog_dn_reg, jog_dn_next;

    smi_md_req_t         md_req;
    smi_md_rsp_t         md_rsp;

    logic                cmd_accept;
    logic [STEP_W-1:0]   idx_inc;
    logic signed [PULSE_W:0] diff;
    logic [PULSE_W-1:0]  mag;
    logic signed [DEG_W-1:0] now_deg;
    logic signed [DEG_W-1:0] jog_target;
    logic [MD_C_W-1:0]   span_div;
    logic [MD_A_W-1:0]   span_a;

    smi_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign command.ready = (state_reg == S_IDLE);
    assign cmd_accept    = command.valid && command.ready;
    assign idx_inc       = idx_reg + STEP_W'(1);

    // Signed distance of the current joint's move and its magnitude
    assign diff = $signed({1'b0, goal_reg[jidx_reg]}) - $signed({1'b0, start_reg[jidx_reg]});
    assign mag  = diff[PULSE_W] ? PULSE_W'(-diff) : diff[PULSE_W-1:0];

    // Jog target from the back-converted angle
    assign now_deg    = $signed({2'b00, md_rsp.q[ANGLE_W-1:0]});
    assign jog_target = jog_dn_reg ? now_deg - $signed({2'b00, jog_deg_reg})
                                   : now_deg + $signed({2'b00, jog_deg_reg});

    // A zero span divides by one with a zero operand, giving angle zero
    assign span_div = (SPAN == 0) ? MD_C_W'(1) : MD_C_W'(SPAN);
    assign span_a   = MD_A_W'(SPAN);

    always_comb
    begin
        state_next      = state_reg;
        set_steps_next  = set_steps_reg;
        home_steps_next = home_steps_reg;
        jog_deg_next    = jog_deg_reg;
        present_next    = present_reg;
        start_next      = start_reg;
        goal_next       = goal_reg;
        res_next        = res_reg;
        pulse_next      = pulse_reg;
        final_next      = final_reg;
        idx_next        = idx_reg;
        total_next      = total_reg;
        moving_next     = moving_reg;
        last_next       = last_reg;
        jidx_next       = jidx_reg;
        sel_next        = sel_reg;
        jog_dn_next     = jog_dn_reg;
        md_req          = '0;
        out_valid_next  = out_valid_reg && !frame.ready;

        // Configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SET_STEPS:  set_steps_next  = cfg_data;
                REG_HOME_STEPS: home_steps_next = cfg_data;
                REG_JOG_DEG:    jog_deg_next    = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    priority if (command.cmd == CMD_TICK)
                    begin
                        if (moving_reg)
                        begin
                            idx_next   = idx_inc;
                            last_next  = (idx_inc >= total_reg);
                            jidx_next  = '0;
                            state_next = S_LAUNCH;
                        end
                    end
                    else if (moving_reg)
                    begin
                        // commands during a move are dropped
                    end
                    else if (command.cmd == CMD_HOME)
                    begin
                        for (int j = 0; j < JOINTS; j++)
                            goal_next[j] = PULSE_W'(HOME_PULSE);
                        start_next  = present_reg;
                        total_next  = (home_steps_reg == '0) ? STEP_W'(1) : home_steps_reg;
                        idx_next    = '0;
                        moving_next = 1'b1;
                    end
                    else if ((command.cmd == CMD_SET || command.cmd == CMD_UP ||
                              command.cmd == CMD_DOWN) && command.joint < JOINT_W'(JOINTS))
                    begin
                        sel_next    = command.joint;
                        jog_dn_next = (command.cmd == CMD_DOWN);
                        md_req.go   = 1'b1;
                        if (command.cmd == CMD_SET)
                        begin
                            // angle to pulse
                            md_req.a   = span_a;
                            md_req.b   = clamp_deg(command.degrees);
                            md_req.c   = MD_C_W'(MAX_DEG);
                            state_next = S_A2P;
                        end
                        else
                        begin
                            // pulse back to angle
                            md_req.a   = (SPAN == 0) ? '0 :
                                         MD_A_W'(present_reg[command.joint] -
                                                 PULSE_W'(PULSE_LOW));
                            md_req.b   = MD_B_W'(MAX_DEG);
                            md_req.c   = span_div;
                            state_next = S_P2A;
                        end
                    end
                    else
                    begin
                        // unknown command or joint out of range
                    end
                end
            end
            S_P2A:
            begin
                if (md_rsp.done)
                begin
                    md_req.go  = 1'b1;
                    md_req.a   = span_a;
                    md_req.b   = clamp_deg(jog_target);
                    md_req.c   = MD_C_W'(MAX_DEG);
                    state_next = S_A2P;
                end
            end
            S_A2P:
            begin
                if (md_rsp.done)
                begin
                    goal_next          = present_reg;
                    goal_next[sel_reg] = PULSE_W'(PULSE_LOW) + md_rsp.q[PULSE_W-1:0];
                    start_next         = present_reg;
                    total_next         = (set_steps_reg == '0) ? STEP_W'(1) : set_steps_reg;
                    idx_next           = '0;
                    moving_next        = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            S_LAUNCH:
            begin
                // |goal - start| * frame / frames for the current joint
                md_req.go  = 1'b1;
                md_req.a   = mag;
                md_req.b   = idx_reg;
                md_req.c   = MD_C_W'(total_reg);
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                if (md_rsp.done)
                begin
                    res_next[jidx_reg] = diff[PULSE_W]
                        ? start_reg[jidx_reg] - md_rsp.q[PULSE_W-1:0]
                        : start_reg[jidx_reg] + md_rsp.q[PULSE_W-1:0];
                    if (jidx_reg == JOINT_W'(JOINTS - 1))
                        state_next = S_OUT;
                    else
                    begin
                        jidx_next  = jidx_reg + 1'b1;
                        state_next = S_LAUNCH;
                    end
                end
            end
            S_OUT:
            begin
                // load the output register once the previous beat is gone
                if (!out_valid_reg || frame.ready)
                begin
                    for (int j = 0; j < ALL_JOINTS; j++)
                        pulse_next[j] = (j < JOINTS) ? res_reg[j] : '0;
                    final_next     = last_reg;
                    out_valid_next = 1'b1;
                    if (last_reg)
                    begin
                        present_next = goal_reg;
                        moving_next  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control and joint state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            set_steps_reg  <= STEP_W'(20);
            home_steps_reg <= STEP_W'(75);
            jog_deg_reg    <= ANGLE_W'(5);
            for (int j = 0; j < ALL_JOINTS; j++)
            begin
                present_reg[j] <= PULSE_W'(HOME_PULSE);
                start_reg[j]   <= PULSE_W'(HOME_PULSE);
                goal_reg[j]    <= PULSE_W'(HOME_PULSE);
            end
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            total_reg      <= '0;
            moving_reg     <= 1'b0;
            last_reg       <= 1'b0;
            jidx_reg       <= '0;
            sel_reg        <= '0;
            jog_dn_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            set_steps_reg  <= set_steps_next;
            home_steps_reg <= home_steps_next;
            jog_deg_reg    <= jog_deg_next;
            present_reg    <= present_next;
            start_reg      <= start_next;
            goal_reg       <= goal_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            total_reg      <= total_next;
            moving_reg     <= moving_next;
            last_reg       <= last_next;
            jidx_reg       <= jidx_next;
            sel_reg        <= sel_next;
            jog_dn_reg     <= jog_dn_next;
        end
    end

    // Result and output payload registers
    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        pulse_reg <= pulse_next;
        final_reg <= final_next;
    end

    assign frame.valid             = out_valid_reg;
    assign frame.pulse_shoulder    = pulse_reg[0];
    assign frame.pulse_elbow       = pulse_reg[1];
    assign frame.pulse_wrist_pitch = pulse_reg[2];
    assign frame.pulse_wrist_roll  = pulse_reg[3];
    assign frame.pulse_grabber     = pulse_reg[4];
    assign frame.pulse_base        = pulse_reg[5];
    assign frame.final_frame       = final_reg;

endmodule

[dv/tb.sv]
// Testbench for the servo motion interpolator: directed table, then phased random moves.
`timescale 1ns / 1ps

module tb;
    import smi_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 300;   // covers the slowest command or frame computation
    localparam int FAULT_SHOWN   = 10;

    localparam logic [CMD_W-1:0]   CMD_RSVD_LO = CMD_HOME + 3'd1;
    localparam logic [CMD_W-1:0]   CMD_RSVD_HI = '1;
    localparam logic [JOINT_W-1:0] JOINT_PAST  = JOINT_W'(JOINTS);
    localparam logic [JOINT_W-1:0] JOINT_TOP   = '1;

    // One frame beat: pulse[0] is the shoulder, pulse[5] the base
    typedef struct packed {
        pulse_t [ALL_JOINTS-1:0] pulse;
        logic                    last;
    } frame_beat_t;

    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_FRAME} exp_kind_t;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic [JOINT_W-1:0]      joint;
        logic signed [DEG_W-1:0] deg;
        int                      reps;
        exp_kind_t               kind;
        frame_beat_t             frame;
    } step_row_t;

    // Shoulder arrives at 180 degrees, the rest stay at the home pulse
    localparam frame_beat_t SHOULDER_AT_TOP =
        {{(ALL_JOINTS-1){pulse_t'(HOME_PULSE)}}, pulse_t'(PULSE_HIGH), 1'b1};

    // Directed steps, run with the reset register values (20, 75, 5)
    step_row_t directed_steps [13] = '{
        '{CMD_TICK,    3'd0,       0,    1,  EXP_NONE,  '0},  // tick with no move running
        '{CMD_RSVD_LO, 3'd3,       100,  1,  EXP_NONE,  '0},  // unused command codes
        '{CMD_RSVD_HI, JOINT_TOP,  -1,   1,  EXP_NONE,  '0},
        '{CMD_SET,     JOINT_PAST, 90,   1,  EXP_NONE,  '0},  // joints past the last one
        '{CMD_UP,      JOINT_TOP,  0,    1,  EXP_NONE,  '0},
        '{CMD_DOWN,    JOINT_PAST, 0,    1,  EXP_NONE,  '0},
        '{CMD_TICK,    3'd5,       -512, 1,  EXP_NONE,  '0},  // nothing was started
        '{CMD_SET,     3'd0,       511,  1,  EXP_NONE,  '0},  // clamps to 180 degrees
        '{CMD_TICK,    3'd7,       511,  10, EXP_MODEL, '0},
        '{CMD_SET,     3'd1,       -512, 1,  EXP_NONE,  '0},  // dropped while moving
        '{CMD_HOME,    3'd2,       0,    1,  EXP_NONE,  '0},  // dropped while moving
        '{CMD_TICK,    3'd0,       0,    9,  EXP_MODEL, '0},
        '{CMD_TICK,    3'd0,       0,    1,  EXP_FRAME, SHOULDER_AT_TOP}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    smi_cmd_if   command_bus ();
    smi_frame_if frame_bus ();

    servo_motion_interpolator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (command_bus),
        .frame     (frame_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted pose and move state
    pulse_t                pose_now  [ALL_JOINTS];
    pulse_t                pose_from [ALL_JOINTS];
    pulse_t                pose_to   [ALL_JOINTS];
    logic [STEP_W-1:0]     frame_no;
    logic [STEP_W-1:0]     frame_span;
    bit                    in_motion;
    logic [CFG_DATA_W-1:0] steps_set;
    logic [CFG_DATA_W-1:0] steps_home;
    logic [CFG_DATA_W-1:0] jog_amount;

    frame_beat_t frames_due [$];
    int          fault_count;
    bit          src_calm;
    bit          snk_calm;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hang guard
    initial
    begin : watchdog
        #12_000_000;
        $display("[servo_motion_interpolator] ERROR");
        $finish;
    end

    function automatic void log_fault(input string msg);
        fault_count++;
        if (fault_count <= FAULT_SHOWN)
            $display("t=%0t %s", $time, msg);
    endfunction

    function automatic string show_beat(input frame_beat_t b);
        return $sformatf("{%0d %0d %0d %0d %0d %0d last=%0d}", b.pulse[0], b.pulse[1],
                         b.pulse[2], b.pulse[3], b.pulse[4], b.pulse[5], b.last);
    endfunction

    // Angle to pulse ticks, angle clamped to 0..180 first
    function automatic pulse_t angle_pulse(input int d);
        int c;
        c = (d < 0) ? 0 : ((d > MAX_DEG) ? MAX_DEG : d);
        return pulse_t'(PULSE_LOW + SPAN * c / MAX_DEG);
    endfunction

    function automatic void start_move(input logic [STEP_W-1:0] steps);
        for (int j = 0; j < JOINTS; j++)
            pose_from[j] = pose_now[j];
        frame_span = (steps == '0) ? STEP_W'(1) : steps;
        frame_no   = '0;
        in_motion  = 1'b1;
    endfunction

    // Apply one command beat to the predicted state; returns 1 when a frame is due
    function automatic bit advance_pose(input logic [CMD_W-1:0] c,
                                        input logic [JOINT_W-1:0] jn,
                                        input logic signed [DEG_W-1:0] d,
                                        output frame_beat_t f);
        int s;
        int g;
        int target;
        f = '0;
        if (c == CMD_TICK)
        begin
            if (!in_motion)
                return 1'b0;
            frame_no = frame_no + 1'b1;
            f.last   = (frame_no >= frame_span);
            for (int j = 0; j < JOINTS; j++)
            begin
                s = int'(pose_from[j]);
                g = int'(pose_to[j]);
                f.pulse[j] = pulse_t'(s + (g - s) * int'(frame_no) / int'(frame_span));
            end
            if (f.last)
            begin
                for (int j = 0; j < JOINTS; j++)
                    pose_now[j] = pose_to[j];
                in_motion = 1'b0;
            end
            return 1'b1;
        end
        if (in_motion)
            return 1'b0;
        if (c == CMD_HOME)
        begin
            for (int j = 0; j < JOINTS; j++)
                pose_to[j] = angle_pulse(HOME_DEG);
            start_move(steps_home);
        end
        else if ((c == CMD_SET || c == CMD_UP || c == CMD_DOWN) && jn < JOINTS)
        begin
            if (c == CMD_SET)
                target = d;
            else
            begin
                // jog starts from the angle of the present pulse
                target = (SPAN == 0) ? 0 : (int'(pose_now[jn]) - PULSE_LOW) * MAX_DEG / SPAN;
                target = (c == CMD_UP) ? target + int'(jog_amount) : target - int'(jog_amount);
            end
            for (int j = 0; j < JOINTS; j++)
                pose_to[j] = pose_now[j];
            pose_to[jn] = angle_pulse(target);
            start_move(steps_set);
        end
        return 1'b0;
    endfunction

    // Angle field biased toward the clamp points and the field extremes
    function automatic logic signed [DEG_W-1:0] pick_angle();
        logic signed [DEG_W-1:0] a;
        case ($urandom_range(11))
            0:       a = DEG_W'($urandom);
            1:       a = '0;
            2:       a = DEG_W'(MAX_DEG);
            3:       a = DEG_W'(MAX_DEG + 1);
            4:       a = {1'b1, {(DEG_W-1){1'b0}}};
            5:       a = {1'b0, {(DEG_W-1){1'b1}}};
            6:       a = '1;
            default: a = DEG_W'($urandom_range(MAX_DEG));
        endcase
        return a;
    endfunction

    // Drive one command beat, wait for the handshake, then predict
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [JOINT_W-1:0] jn,
                             input logic signed [DEG_W-1:0] d, input exp_kind_t kind,
                             input frame_beat_t typed);
        int          gap;
        bit          has_frame;
        frame_beat_t f;
        gap = src_calm ? 0 : $urandom_range(8);
        @(negedge clk);
        if (gap > 0)
        begin
            command_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        command_bus.valid   = 1'b1;
        command_bus.cmd     = c;
        command_bus.joint   = jn;
        command_bus.degrees = d;
        do @(posedge clk); while (command_bus.ready !== 1'b1);
        has_frame = advance_pose(c, jn, d, f);
        if (kind == EXP_FRAME)
            frames_due.push_back(typed);
        else if (kind == EXP_MODEL && has_frame)
            frames_due.push_back(f);
    endtask

    // Hold the command channel until every predicted frame has been taken
    task automatic drain_frames();
        @(negedge clk);
        command_bus.valid = 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_SET_STEPS:  steps_set  = v;
            REG_HOME_STEPS: steps_home = v;
            REG_JOG_DEG:    jog_amount = v;
            default: ;
        endcase
    endtask

    // Registers change only with the block idle and all frames taken
    task automatic reconfigure(input logic [CFG_DATA_W-1:0] s, input logic [CFG_DATA_W-1:0] h,
                               input logic [CFG_DATA_W-1:0] jg);
        drain_frames();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_SET_STEPS, s);
        write_reg(REG_HOME_STEPS, h);
        write_reg(REG_JOG_DEG, jg);
    endtask

    // Random moves: a command when idle, mostly ticks while moving, some noise.
    // The leading commands (CMD_TICK for none) open the phase; the last move always completes.
    task automatic run_phase(input int budget, input logic [CMD_W-1:0] lead_a,
                             input logic [CMD_W-1:0] lead_b);
        int                      sent;
        int                      r;
        logic [CMD_W-1:0]        c;
        logic [JOINT_W-1:0]      jn;
        logic signed [DEG_W-1:0] d;
        sent = 0;
        while (sent < budget || in_motion)
        begin
            jn = JOINT_W'($urandom_range(JOINTS - 1));
            d  = pick_angle();
            r  = $urandom_range(99);
            if (in_motion)
            begin
                if (r < 88)
                begin
                    c  = CMD_TICK;
                    jn = JOINT_W'($urandom);
                    d  = DEG_W'($urandom);
                end
                else
                begin
                    c  = CMD_W'($urandom_range(CMD_RSVD_HI, CMD_SET));
                    jn = JOINT_W'($urandom);
                end
            end
            else if (lead_a != CMD_TICK)
            begin
                c      = lead_a;
                lead_a = lead_b;
                lead_b = CMD_TICK;
            end
            else if (r < 4)
                c = CMD_TICK;
            else if (r < 7)
                c = CMD_W'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
            else if (r < 10)
            begin
                c  = CMD_W'($urandom_range(CMD_DOWN, CMD_SET));
                jn = JOINT_W'($urandom_range(JOINT_TOP, JOINT_PAST));
            end
            else if (r < 45)
                c = CMD_SET;
            else if (r < 65)
                c = CMD_UP;
            else if (r < 85)
                c = CMD_DOWN;
            else
                c = CMD_HOME;
            if ($urandom_range(59) == 0)
                src_calm = !src_calm;
            if (sent == 5 || $urandom_range(39) == 0)
                drain_frames();
            send_item(c, jn, d, EXP_MODEL, '0);
            sent++;
        end
    endtask

    // Frame sink: random stall per beat, compare against the oldest prediction
    initial
    begin : frame_sink
        int          stall;
        bit          bad;
        frame_beat_t seen;
        frame_beat_t want;
        frame_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(49) == 0)
                snk_calm = !snk_calm;
            stall = snk_calm ? 0 : $urandom_range(8);
            if (stall > 0)
            begin
                frame_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            frame_bus.ready = 1'b1;
            do @(posedge clk); while (frame_bus.valid !== 1'b1);
            seen.pulse[0] = frame_bus.pulse_shoulder;
            seen.pulse[1] = frame_bus.pulse_elbow;
            seen.pulse[2] = frame_bus.pulse_wrist_pitch;
            seen.pulse[3] = frame_bus.pulse_wrist_roll;
            seen.pulse[4] = frame_bus.pulse_grabber;
            seen.pulse[5] = frame_bus.pulse_base;
            seen.last     = frame_bus.final_frame;
            if (frames_due.size() == 0)
                log_fault($sformatf("unexpected frame beat %s", show_beat(seen)));
            else
            begin
                want = frames_due.pop_front();
                bad  = (seen.last !== want.last);
                for (int j = 0; j < ALL_JOINTS; j++)
                    if (seen.pulse[j] !== want.pulse[j])
                        bad = 1'b1;
                if (bad)
                    log_fault($sformatf("frame mismatch: expected %s got %s",
                                        show_beat(want), show_beat(seen)));
            end
        end
    end

    initial
    begin : stimulus
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        command_bus.valid   = 1'b0;
        command_bus.cmd     = CMD_TICK;
        command_bus.joint   = '0;
        command_bus.degrees = '0;
        fault_count         = 0;
        src_calm            = 1'b0;
        snk_calm            = 1'b0;

        // predicted state after reset
        for (int j = 0; j < ALL_JOINTS; j++)
        begin
            pose_now[j]  = pulse_t'(HOME_PULSE);
            pose_from[j] = pulse_t'(HOME_PULSE);
            pose_to[j]   = pulse_t'(HOME_PULSE);
        end
        frame_no   = '0;
        frame_span = '0;
        in_motion  = 1'b0;
        steps_set  = 8'd20;
        steps_home = 8'd75;
        jog_amount = 8'd5;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_steps[i])
            repeat (directed_steps[i].reps)
                send_item(directed_steps[i].cmd, directed_steps[i].joint,
                          directed_steps[i].deg, directed_steps[i].kind,
                          directed_steps[i].frame);

        // reset register values: a home move over 75 frames first
        run_phase(20, CMD_HOME, CMD_TICK);

        // one-frame moves, zero jog, no idling on either side
        src_calm = 1'b1;
        snk_calm = 1'b1;
        reconfigure(8'd1, 8'd1, 8'd0);
        run_phase(40, CMD_UP, CMD_SET);

        // zero step counts run one frame; jog wider than the full range
        src_calm = 1'b0;
        snk_calm = 1'b0;
        reconfigure(8'd0, 8'd0, 8'd255);
        run_phase(30, CMD_HOME, CMD_DOWN);

        // longest moves for both counts
        reconfigure(8'd255, 8'd255, 8'd180);
        run_phase(2, CMD_SET, CMD_HOME);

        repeat (3)
        begin
            src_calm = ($urandom_range(2) == 0);
            snk_calm = ($urandom_range(2) == 0);
            reconfigure(CFG_DATA_W'($urandom_range(12, 1)), CFG_DATA_W'($urandom_range(12, 1)),
                        CFG_DATA_W'($urandom_range(MAX_DEG)));
            run_phase(30, CMD_TICK, CMD_TICK);
        end

        drain_frames();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("[servo_motion_interpolator] OK");
        else
            $display("[servo_motion_interpolator] ERROR");
        $finish;
    end

endmodule
